// ----- rtl/core/aesc_pkg.sv -----
package aesc_pkg;

  localparam int unsigned KeyLenW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RkDepth = 15;
  localparam int unsigned RkAddrW = 4;

  localparam logic [CfgIdxW-1:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_0 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_1 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_2 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_3 = 3'd4;

  localparam logic [KeyLenW-1:0] KEY_128 = 2'd0;
  localparam logic [KeyLenW-1:0] KEY_192 = 2'd1;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
  } in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_t;

  typedef struct packed {
    logic decrypt;
    logic first;
    logic last;
  } round_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ----- rtl/core/aesc_round.sv -----
module aesc_round
  import aesc_pkg::*;
(
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  round_ctl_t   ctl_i,
  output logic [127:0] state_o
);

  logic [7:0]   s     [16];
  logic [7:0]   fs    [16];
  logic [7:0]   is    [16];
  logic [127:0] fs_v;
  logic [127:0] is_v;
  logic [127:0] fmix;
  logic [127:0] imix;
  logic [127:0] iadd;

  // byte i sits at bits 127-8i; row r, column c is byte r+4c
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fs[r+4*c] = SBOX[s[r+4*((c+r)%4)]];
        is[r+4*c] = INV_SBOX[s[r+4*((c-r+4)%4)]];
      end
    end
    for (int i = 0; i < 16; i++) begin
      fs_v[127-8*i -: 8] = fs[i];
      is_v[127-8*i -: 8] = is[i];
    end
  end

  assign iadd = is_v ^ rkey_i;

  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] b0, b1, b2, b3;
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] v  [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    fmix = '0;
    imix = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = fs_v[127-32*c -: 8];
      a1 = fs_v[119-32*c -: 8];
      a2 = fs_v[111-32*c -: 8];
      a3 = fs_v[103-32*c -: 8];
      b0 = xt(a0);
      b1 = xt(a1);
      b2 = xt(a2);
      b3 = xt(a3);
      fmix[127-32*c -: 32] = {b0 ^ b1 ^ a1 ^ a2 ^ a3,
                              a0 ^ b1 ^ b2 ^ a2 ^ a3,
                              a0 ^ a1 ^ b2 ^ b3 ^ a3,
                              b0 ^ a0 ^ a1 ^ a2 ^ b3};
      for (int k = 0; k < 4; k++) begin
        v[k]  = iadd[127-32*c-8*k -: 8];
        x2[k] = xt(v[k]);
        x4[k] = xt(x2[k]);
        x8[k] = xt(x4[k]);
        m9[k] = x8[k] ^ v[k];
        mb[k] = x8[k] ^ x2[k] ^ v[k];
        md[k] = x8[k] ^ x4[k] ^ v[k];
        me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      imix[127-32*c -: 32] = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                              m9[0] ^ me[1] ^ mb[2] ^ md[3],
                              md[0] ^ m9[1] ^ me[2] ^ mb[3],
                              mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    end
  end

  always_comb begin
    priority if (ctl_i.first) begin
      state_o = state_i ^ rkey_i;
    end else if (ctl_i.decrypt) begin
      state_o = ctl_i.last ? iadd : imix;
    end else begin
      state_o = (ctl_i.last ? fs_v : fmix) ^ rkey_i;
    end
  end

endmodule

// ----- rtl/core/aes_block_cipher.sv -----
// Channel  Dir  Signals                         Payload
// in       in   in_valid / in_ready             in_data (opcode, data_hi, data_lo)
// out      out  out_valid / out_ready           out_data (result_hi, result_lo)
// cfg      in   cfg_valid / cfg_ready           cfg_index, cfg_data
//
// After acceptance the core reads the first round key (S_LOAD), runs the key add plus nr
// rounds (nr = 10, 12 or 14) in the shared round unit (S_ROUND) and registers the result
// (S_OUT). A new request is taken only in S_IDLE, so one block is processed at a time.
// The first request after reset or a key or key length write first expands the key into
// the round key memory, one word a cycle: 4*(nr+1) words (44, 52 or 60).
// Reset clears the control and key registers and marks the schedule stale. A stalled
// result holds the output register; the next request is taken while it waits, and the
// core waits at the end of that request until the register frees.
module aes_block_cipher
  import aesc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXPAND = 5'b00010,
    S_LOAD   = 5'b00100,
    S_ROUND  = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t              st_r, st_nxt;
  logic [KeyLenW-1:0]  klen_r;
  logic [63:0]         key_r [4];
  logic                sched_ok_r, sched_ok_nxt;
  logic [127:0]        blk_r, blk_nxt;
  logic                dec_r, dec_nxt;
  logic [3:0]          rnd_r, rnd_nxt;
  logic [5:0]          wi_r, wi_nxt;
  logic [2:0]          kc_r, kc_nxt;
  logic [7:0]          rc_r, rc_nxt;
  logic [31:0]         win_r [8];
  logic [95:0]         row_r;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r;

  logic [127:0]        rk_mem [RkDepth];
  logic [127:0]        rk_q;
  logic [RkAddrW-1:0]  rd_addr;
  logic                rk_we;
  logic [127:0]        rk_wd;

  logic [3:0]          nk;
  logic [3:0]          nr;
  logic [2:0]          back_idx;
  logic [31:0]         kw, tw, neww;
  logic [3:0]          step_nxt;
  logic                out_free;
  round_ctl_t          rctl;
  logic [127:0]        round_out;

  always_comb begin
    unique case (klen_r)
      KEY_128: nk = 4'd4;
      KEY_192: nk = 4'd6;
      default: nk = 4'd8;
    endcase
  end
  assign nr       = nk + 4'd6;
  assign back_idx = 3'(4'd8 - nk);

  assign in_ready  = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KEY_128;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_LENGTH: klen_r   <= cfg_data[KeyLenW-1:0];
        CFG_KEY_WORD_0: key_r[0] <= cfg_data;
        CFG_KEY_WORD_1: key_r[1] <= cfg_data;
        CFG_KEY_WORD_2: key_r[2] <= cfg_data;
        CFG_KEY_WORD_3: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // key expansion, one schedule word per cycle
  always_comb begin
    kw = wi_r[0] ? key_r[wi_r[2:1]][31:0] : key_r[wi_r[2:1]][63:32];
    tw = win_r[7];
    if (kc_r == 3'd0) begin
      tw = sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rc_r, 24'h0};
    end else if (nk == 4'd8 && kc_r == 3'd4) begin
      tw = sub_word(win_r[7]);
    end
    neww = (wi_r < 6'(nk)) ? kw : (win_r[back_idx] ^ tw);
  end

  assign rk_we = (st_r == S_EXPAND) && (wi_r[1:0] == 2'b11);
  assign rk_wd = {row_r, neww};

  always_ff @(posedge clk) begin
    if (st_r == S_EXPAND) begin
      row_r <= {row_r[63:0], neww};
      for (int i = 0; i < 7; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[7] <= neww;
    end
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[wi_r[5:2]] <= rk_wd;
    end
    rk_q <= rk_mem[rd_addr];
  end

  assign step_nxt = (rnd_r == nr) ? 4'd0 : rnd_r + 4'd1;

  always_comb begin
    if (st_r == S_LOAD) begin
      rd_addr = (dec_r == OP_DECRYPT) ? nr : 4'd0;
    end else begin
      rd_addr = (dec_r == OP_DECRYPT) ? ((rnd_r == nr) ? 4'd0 : nr - step_nxt) : step_nxt;
    end
  end

  assign rctl.decrypt = (dec_r == OP_DECRYPT);
  assign rctl.first   = (rnd_r == 4'd0);
  assign rctl.last    = (rnd_r == nr);

  aesc_round u_round (
    .state_i (blk_r),
    .rkey_i  (rk_q),
    .ctl_i   (rctl),
    .state_o (round_out)
  );

  always_comb begin
    st_nxt        = st_r;
    sched_ok_nxt  = sched_ok_r;
    blk_nxt       = blk_r;
    dec_nxt       = dec_r;
    rnd_nxt       = rnd_r;
    wi_nxt        = wi_r;
    kc_nxt        = kc_r;
    rc_nxt        = rc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          blk_nxt = {in_data.data_hi, in_data.data_lo};
          dec_nxt = in_data.opcode;
          wi_nxt  = '0;
          kc_nxt  = '0;
          rc_nxt  = 8'h01;
          st_nxt  = sched_ok_r ? S_LOAD : S_EXPAND;
        end
      end
      S_EXPAND: begin
        wi_nxt = wi_r + 6'd1;
        kc_nxt = (kc_r == 3'(nk - 4'd1)) ? 3'd0 : kc_r + 3'd1;
        if (wi_r >= 6'(nk) && kc_r == 3'd0) begin
          rc_nxt = xt(rc_r);
        end
        if (wi_r == {nr, 2'b11}) begin
          sched_ok_nxt = 1'b1;
          st_nxt       = S_LOAD;
        end
      end
      S_LOAD: begin
        rnd_nxt = '0;
        st_nxt  = S_ROUND;
      end
      S_ROUND: begin
        blk_nxt = round_out;
        rnd_nxt = step_nxt;
        if (rnd_r == nr) begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (cfg_valid && cfg_index <= CFG_KEY_WORD_3) begin
      sched_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      sched_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rnd_r       <= '0;
      wi_r        <= '0;
      kc_r        <= '0;
      rc_r        <= 8'h01;
    end else begin
      st_r        <= st_nxt;
      sched_ok_r  <= sched_ok_nxt;
      out_valid_r <= out_valid_nxt;
      rnd_r       <= rnd_nxt;
      wi_r        <= wi_nxt;
      kc_r        <= kc_nxt;
      rc_r        <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    dec_r <= dec_nxt;
    if (st_r == S_OUT && out_free) begin
      out_data_r <= {blk_r[127:64], blk_r[63:0]};
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_ROUND |-> rnd_r <= nr)
    else $error("round counter past last round");

  a_expand_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_EXPAND |-> wi_r <= {nr, 2'b11})
    else $error("key expansion ran past schedule end");

  a_key_write_stale: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index == CFG_KEY_WORD_0 |=> !sched_ok_r)
    else $error("key write left schedule marked current");

  a_load_needs_sched: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_LOAD |-> sched_ok_r)
    else $error("rounds started on a stale schedule");

endmodule

// ----- bench/aes_block_cipher_tb.sv -----
`timescale 1ns / 100ps

module aes_block_cipher_tb;
  import aesc_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0]        cfg_data;

  aes_block_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the key registers used by the cipher model.
  logic [KeyLenW-1:0] key_len_q;
  logic [63:0]        key_words_q [4];

  in_t   pending_blocks [$];
  out_t  expected_blocks [$];
  int    fail_count = 0;
  int    idle_cycles = 0;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    hold_off_cycles = 0;
  bit    hold_armed = 1'b1;
  int    phase_no;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic out_t cipher_block(input in_t req);
    logic [31:0] rk [60];
    logic [7:0]  st [16];
    logic [7:0]  tmp [16];
    logic [7:0]  col [4];
    logic [7:0]  mc [4];
    logic [7:0]  acc;
    logic [7:0]  rcon;
    logic [31:0] t;
    logic [63:0] kw;
    out_t        res;
    int          nk;
    int          nr;
    int          src;
    nk = (key_len_q == KEY_128) ? 4 : (key_len_q == KEY_192) ? 6 : 8;
    nr = nk + 6;
    rcon = 8'h01;
    for (int i = 0; i < nk; i++) begin
      kw = key_words_q[i / 2];
      rk[i] = (i % 2) ? kw[31:0] : kw[63:32];
    end
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = rk[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
      end else if (nk == 8 && i % nk == 4) begin
        t = sbox_word(t);
      end
      rk[i] = rk[i - nk] ^ t;
    end
    for (int i = 0; i < 8; i++) begin
      st[i]     = req.data_hi[63 - 8 * i -: 8];
      st[i + 8] = req.data_lo[63 - 8 * i -: 8];
    end
    for (int step = 0; step <= nr; step++) begin
      // round number walked forward for encrypt, backward for decrypt
      automatic int rnd = (req.opcode == OP_DECRYPT) ? nr - step : step;
      if (step > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            src = r + 4 * ((c + r) % 4);
            if (req.opcode == OP_DECRYPT) tmp[src] = INV_SBOX[st[r + 4 * c]];
            else tmp[r + 4 * c] = SBOX[st[src]];
          end
        st = tmp;
        if (req.opcode == OP_ENCRYPT && step < nr) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) col[r] = st[r + 4 * c];
            mc = '{8'd2, 8'd3, 8'd1, 8'd1};
            for (int r = 0; r < 4; r++) begin
              acc = 8'h00;
              for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], mc[(k - r + 4) % 4]);
              st[r + 4 * c] = acc;
            end
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          st[r + 4 * c] ^= rk[4 * rnd + c][31 - 8 * r -: 8];
      if (req.opcode == OP_DECRYPT && step > 0 && step < nr) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) col[r] = st[r + 4 * c];
          mc = '{8'd14, 8'd11, 8'd13, 8'd9};
          for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], mc[(k - r + 4) % 4]);
            st[r + 4 * c] = acc;
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.result_hi[63 - 8 * i -: 8] = st[i];
      res.result_lo[63 - 8 * i -: 8] = st[i + 8];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_t rand_block();
    in_t b;
    b.opcode  = 1'($urandom_range(0, 1));
    b.data_hi = rand64();
    b.data_lo = rand64();
    case ($urandom_range(0, 9))
      0: b.data_hi = '0;
      1: b.data_lo = '1;
      default: ;
    endcase
    return b;
  endfunction

  // Driver: input requests.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_blocks.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_blocks.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance, with the key registers current at that time.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_blocks.push_back(cipher_block(in_data));
  end

  // Receiver readiness, with one long hold-off stretch in phase four.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_off_cycles <= 0;
    end else if (hold_armed && phase_no == 4) begin
      hold_armed <= 1'b0;
      hold_off_cycles <= 400;
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    out_t exp_blk;
    if (rst_n && out_valid && out_ready) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (out_data.result_hi !== exp_blk.result_hi) begin
          $display("%0t: result_hi expected %h actual %h", $time, exp_blk.result_hi,
                   out_data.result_hi);
          fail_count++;
        end
        if (out_data.result_lo !== exp_blk.result_lo) begin
          $display("%0t: result_lo expected %h actual %h", $time, exp_blk.result_lo,
                   out_data.result_lo);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n || hold_off_cycles > 0) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_KEY_LENGTH) key_len_q = val[KeyLenW-1:0];
    else if (idx <= CFG_KEY_WORD_3) key_words_q[idx - 1] = val;
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() > 0 || in_valid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] klen);
    write_reg(CFG_KEY_LENGTH, 64'(klen));
    write_reg(CFG_KEY_WORD_0, rand64());
    write_reg(CFG_KEY_WORD_1, rand64());
    write_reg(CFG_KEY_WORD_2, rand64());
    write_reg(CFG_KEY_WORD_3, rand64());
  endtask

  initial begin
    in_t blk;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    phase_no = -1;
    key_len_q = KEY_128;
    for (int i = 0; i < 4; i++) key_words_q[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset key, FIPS vectors, extremes, length code three.
    pending_blocks.push_back('{OP_ENCRYPT, 64'h0, 64'h0});
    pending_blocks.push_back('{OP_DECRYPT, '1, '1});
    wait_drained();
    write_reg(CFG_KEY_WORD_0, 64'h0001020304050607);
    write_reg(CFG_KEY_WORD_1, 64'h08090a0b0c0d0e0f);
    write_reg(CFG_KEY_WORD_2, 64'h1011121314151617);
    write_reg(CFG_KEY_WORD_3, 64'h18191a1b1c1d1e1f);
    for (int k = 0; k < 4; k++) begin
      if (k > 0) write_reg(CFG_KEY_LENGTH, 64'(k));
      pending_blocks.push_back('{OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff});
      pending_blocks.push_back('{OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
      pending_blocks.push_back('{OP_ENCRYPT, '1, '1});
      pending_blocks.push_back('{OP_DECRYPT, 64'h0, 64'h0});
      wait_drained();
    end
    // out of range index is ignored
    write_reg(3'd7, '1);
    write_reg(3'd5, '1);
    write_reg(CFG_KEY_WORD_0, '1);
    write_reg(CFG_KEY_WORD_3, '1);
    pending_blocks.push_back('{OP_ENCRYPT, 64'h8000000000000001, 64'h0123456789abcdef});
    wait_drained();

    // Random phases across idling modes and key settings.
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? 85 : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 85 : 0;
      if (ph % 4 == 3) begin
        send_idle_pct = 29;
        recv_stall_pct = 29;
      end
      load_key(2'(ph % 4));
      if (ph % 2 == 0) write_reg(CFG_KEY_LENGTH, 64'($urandom_range(0, 3)));
      phase_no = ph;
      for (int n = 0; n < 152; n++) begin
        blk = rand_block();
        pending_blocks.push_back(blk);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/aesc_pkg.sv
rtl/core/aesc_round.sv
rtl/core/aes_block_cipher.sv
bench/aes_block_cipher_tb.sv
